### hw/rtl/cerf_pkg.sv
// Shared types and constants for the 3x3 replicate-border convolution filter.
// No dependencies; imported by every module of the block except cerf_ram.
`default_nettype none
package cerf_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 11;

    localparam int PIX_BITS    = 16;                   // pixel_in / pixel_out field width
    localparam int COL_BITS    = $clog2(MAX_WIDTH);    // line buffer address
    localparam int FW_BITS     = 13;                   // frame_width field
    localparam int FH_BITS     = 16;                   // frame_height field
    localparam int ROWREG_BITS = 3 * COEF_BITS;
    localparam int SCALE_BITS  = 24;
    localparam int BIAS_BITS   = 25;
    localparam int MAXV_BITS   = 16;
    localparam int FRAC_BITS   = 16;
    localparam int BIAS_FRAC   = 8;

    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS + 1;
    localparam int ACC_BITS    = PROD_BITS + 4;        // nine products
    localparam int SPROD_BITS  = ACC_BITS + SCALE_BITS;
    localparam int V_BITS      = SPROD_BITS + 2;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    // register indexes
    localparam logic [2:0] REG_COEF_TOP  = 3'd0;
    localparam logic [2:0] REG_COEF_MID  = 3'd1;
    localparam logic [2:0] REG_COEF_BOT  = 3'd2;
    localparam logic [2:0] REG_SCALE     = 3'd3;
    localparam logic [2:0] REG_BIAS      = 3'd4;
    localparam logic [2:0] REG_MAXV      = 3'd5;
    localparam logic [2:0] REG_FWIDTH    = 3'd6;
    localparam logic [2:0] REG_FHEIGHT   = 3'd7;

    localparam int PADDR_BITS  = 6;
    localparam int PDATA_BITS  = 64;

    typedef struct packed {
        logic                req_type;
        logic [PIX_BITS-1:0] pixel_in;
    } t_in;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel_out;
        logic                row_end;
        logic                frame_end;
    } t_out;

    typedef struct packed {
        logic [ROWREG_BITS-1:0]       coef_top;
        logic [ROWREG_BITS-1:0]       coef_mid;
        logic [ROWREG_BITS-1:0]       coef_bot;
        logic signed [SCALE_BITS-1:0] scale;
        logic signed [BIAS_BITS-1:0]  bias;
        logic [MAXV_BITS-1:0]         max_value;
        logic [FW_BITS-1:0]           frame_width;
        logic [FH_BITS-1:0]           frame_height;
    } t_cfg;

    typedef struct packed {
        logic                latch_in;   // capture request sample
        logic [COL_BITS-1:0] ram_addr;
        logic                wr_cur;
        logic                wr_above;
        logic                shift;      // load new window column from line buffers and request sample
        logic                top_is_mid; // second row: replicate upward
        logic                flush;
        logic                mac_en;
        logic                acc_clr;
        logic [1:0]          tap_row;
        logic [1:0]          tap_k;
        logic [1:0]          win_col;
        logic                scale_en;
        logic                load_out;
        logic                row_end;
        logic                frame_end;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

### hw/rtl/cerf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module cerf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

### hw/rtl/cerf_cfg.sv
// APB register file of the convolution filter.
// Depends on cerf_pkg.
`default_nettype none
module cerf_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cerf_pkg::PADDR_BITS-1:0] paddr,
    input  wire logic [cerf_pkg::PDATA_BITS-1:0] pwdata,
    output logic      [cerf_pkg::PDATA_BITS-1:0] prdata,
    output cerf_pkg::t_cfg                       o_cfg
);
    import cerf_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr;

    assign idx = paddr[5:3];
    assign wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_top     <= '0;
            r_cfg.coef_mid     <= ROWREG_BITS'(2048);
            r_cfg.coef_bot     <= '0;
            r_cfg.scale        <= SCALE_BITS'(65536);
            r_cfg.bias         <= '0;
            r_cfg.max_value    <= MAXV_BITS'(255);
            r_cfg.frame_width  <= FW_BITS'(640);
            r_cfg.frame_height <= FH_BITS'(480);
        end else if (wr) begin
            unique case (idx)
                REG_COEF_TOP: r_cfg.coef_top     <= pwdata[ROWREG_BITS-1:0];
                REG_COEF_MID: r_cfg.coef_mid     <= pwdata[ROWREG_BITS-1:0];
                REG_COEF_BOT: r_cfg.coef_bot     <= pwdata[ROWREG_BITS-1:0];
                REG_SCALE:    r_cfg.scale        <= pwdata[SCALE_BITS-1:0];
                REG_BIAS:     r_cfg.bias         <= pwdata[BIAS_BITS-1:0];
                REG_MAXV:     r_cfg.max_value    <= pwdata[MAXV_BITS-1:0];
                REG_FWIDTH:   r_cfg.frame_width  <= pwdata[FW_BITS-1:0];
                REG_FHEIGHT:  r_cfg.frame_height <= pwdata[FH_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_COEF_TOP: prdata = PDATA_BITS'(r_cfg.coef_top);
            REG_COEF_MID: prdata = PDATA_BITS'(r_cfg.coef_mid);
            REG_COEF_BOT: prdata = PDATA_BITS'(r_cfg.coef_bot);
            REG_SCALE:    prdata = PDATA_BITS'($unsigned(r_cfg.scale));
            REG_BIAS:     prdata = PDATA_BITS'($unsigned(r_cfg.bias));
            REG_MAXV:     prdata = PDATA_BITS'(r_cfg.max_value);
            REG_FWIDTH:   prdata = PDATA_BITS'(r_cfg.frame_width);
            REG_FHEIGHT:  prdata = PDATA_BITS'(r_cfg.frame_height);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

### hw/rtl/cerf_datapath.sv
// Datapath: line buffers, 3x3 window, shared tap MAC, scale, round, clamp, output register.
// Depends on cerf_pkg and cerf_ram.
`default_nettype none
module cerf_datapath (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  cerf_pkg::t_cfg             i_cfg,
    input  cerf_pkg::t_in              i_in_data,
    input  cerf_pkg::t_dp_cmd          i_cmd,
    output cerf_pkg::t_dp_status       o_status,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output cerf_pkg::t_out             o_out_data
);
    import cerf_pkg::*;

    logic [SAMPLE_BITS-1:0] pix_in;
    logic [SAMPLE_BITS-1:0] r_pix;
    logic [SAMPLE_BITS-1:0] cur_rdata, above_rdata, cur_wdata;
    logic [SAMPLE_BITS-1:0] col_top, col_bot;
    logic [SAMPLE_BITS-1:0] r_win [3][3];
    logic [SAMPLE_BITS-1:0] win_pix;
    logic [ROWREG_BITS-1:0] coef_row;
    logic signed [COEF_BITS-1:0]  coef;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [ACC_BITS-1:0]   r_acc;
    logic signed [SPROD_BITS-1:0] r_sprod;
    logic signed [V_BITS-1:0]     v;
    logic [V_BITS-FRAC_BITS-1:0]  q;
    logic [SAMPLE_BITS-1:0]       lim;
    logic [PIX_BITS-1:0]          res;
    logic                         r_out_valid;
    t_out                         r_out;

    assign pix_in    = i_in_data.pixel_in[SAMPLE_BITS-1:0];
    assign cur_wdata = i_cmd.shift ? r_pix : pix_in;

    cerf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_line_cur (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_cur),
        .i_addr (i_cmd.ram_addr),
        .i_wdata(cur_wdata),
        .o_rdata(cur_rdata)
    );

    cerf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_line_above (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_above),
        .i_addr (i_cmd.ram_addr),
        .i_wdata(cur_rdata),
        .o_rdata(above_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_pix <= pix_in;
        end
    end

    assign col_top = i_cmd.top_is_mid ? cur_rdata : above_rdata;
    assign col_bot = i_cmd.flush ? cur_rdata : r_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_cmd.shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= col_top;
            r_win[1][2] <= cur_rdata;
            r_win[2][2] <= col_bot;
        end
    end

    // one tap per cycle
    always_comb begin
        case (i_cmd.tap_row)
            2'd0:    coef_row = i_cfg.coef_top;
            2'd1:    coef_row = i_cfg.coef_mid;
            default: coef_row = i_cfg.coef_bot;
        endcase
        case (i_cmd.tap_k)
            2'd0:    coef = coef_row[0*COEF_BITS +: COEF_BITS];
            2'd1:    coef = coef_row[1*COEF_BITS +: COEF_BITS];
            default: coef = coef_row[2*COEF_BITS +: COEF_BITS];
        endcase
        win_pix = r_win[i_cmd.tap_row][i_cmd.win_col];
    end

    assign prod = PROD_BITS'(coef * $signed({1'b0, win_pix}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_en) begin
            if (i_cmd.acc_clr) begin
                r_acc <= ACC_BITS'(prod);
            end else begin
                r_acc <= r_acc + ACC_BITS'(prod);
            end
        end
        if (i_cmd.scale_en) begin
            r_sprod <= SPROD_BITS'(r_acc * i_cfg.scale);
        end
    end

    // round half up, clamp to [0, lim]
    always_comb begin
        v   = V_BITS'(r_sprod) + (V_BITS'(i_cfg.bias) <<< BIAS_FRAC)
            + V_BITS'(1 << (FRAC_BITS - 1));
        q   = v[V_BITS-1:FRAC_BITS];
        lim = (i_cfg.max_value > MAXV_BITS'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                         : SAMPLE_BITS'(i_cfg.max_value);
        if (v[V_BITS-1]) begin
            res = '0;
        end else if (q > (V_BITS-FRAC_BITS)'(lim)) begin
            res = PIX_BITS'(lim);
        end else begin
            res = PIX_BITS'(q);
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out.pixel_out <= res;
            r_out.row_end   <= i_cmd.row_end;
            r_out.frame_end <= i_cmd.frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

### hw/rtl/cerf_ctrl.sv
// Controller: raster counters, request decode and the per-request sequence.
// Depends on cerf_pkg.
`default_nettype none
module cerf_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  cerf_pkg::t_cfg           i_cfg,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  cerf_pkg::t_in            i_in_data,
    input  cerf_pkg::t_dp_status     i_status,
    output cerf_pkg::t_dp_cmd        o_cmd
);
    import cerf_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [COL_BITS-1:0] r_col, r_icol;
    logic [FH_BITS-1:0]  r_row;
    logic                r_iflush, r_itop_mid, r_ilast, r_modeb;
    logic [1:0]          r_tr, r_tk;

    logic [FW_BITS-1:0]  w_eff;
    logic [FH_BITS-1:0]  h_eff;
    logic [COL_BITS-1:0] c_eff;
    logic                flush, ignore, last_col, accept;

    always_comb begin
        if (i_cfg.frame_width < FW_BITS'(2)) begin
            w_eff = FW_BITS'(2);
        end else if (i_cfg.frame_width > FW_BITS'(MAX_WIDTH)) begin
            w_eff = FW_BITS'(MAX_WIDTH);
        end else begin
            w_eff = i_cfg.frame_width;
        end
        h_eff    = (i_cfg.frame_height == '0) ? FH_BITS'(1) : i_cfg.frame_height;
        c_eff    = (FW_BITS'(r_col) >= w_eff) ? '0 : r_col;
        flush    = i_in_data.req_type;
        ignore   = (!flush && r_row >= h_eff) || (flush && r_row < h_eff);
        last_col = (FW_BITS'(c_eff) + FW_BITS'(1)) >= w_eff;
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept && !ignore && r_row != '0) n_state = ST_SHIFT;
            ST_SHIFT: n_state = (r_icol != '0 || r_ilast) ? ST_MAC : ST_IDLE;
            ST_MAC:   if (r_tr == 2'd2 && r_tk == 2'd2) n_state = ST_SCALE;
            ST_SCALE: n_state = ST_EMIT;
            ST_EMIT:  if (i_status.out_free) n_state = (!r_modeb && r_ilast) ? ST_MAC : ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_tr    <= '0;
            r_tk    <= '0;
            r_modeb <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                if (ignore) begin
                    r_col <= c_eff;
                end else if (last_col) begin
                    r_col <= '0;
                    r_row <= flush ? '0 : r_row + FH_BITS'(1);
                end else begin
                    r_col <= c_eff + COL_BITS'(1);
                end
            end
            if (r_state == ST_SHIFT) begin
                r_modeb <= (r_icol == '0);
            end else if (r_state == ST_EMIT && i_status.out_free) begin
                r_modeb <= 1'b1;
            end
            if (r_state == ST_MAC) begin
                if (r_tk == 2'd2) begin
                    r_tk <= '0;
                    r_tr <= (r_tr == 2'd2) ? 2'd0 : r_tr + 2'd1;
                end else begin
                    r_tk <= r_tk + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_icol     <= c_eff;
            r_iflush   <= flush;
            r_itop_mid <= (r_row == FH_BITS'(1));
            r_ilast    <= last_col;
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.latch_in   = accept;
        o_cmd.ram_addr   = (r_state == ST_IDLE) ? c_eff : r_icol;
        o_cmd.wr_cur     = (accept && !ignore && r_row == '0)
                           || (r_state == ST_SHIFT && !r_iflush);
        o_cmd.wr_above   = (r_state == ST_SHIFT) && !r_iflush;
        o_cmd.shift      = (r_state == ST_SHIFT);
        o_cmd.top_is_mid = r_itop_mid;
        o_cmd.flush      = r_iflush;
        o_cmd.mac_en     = (r_state == ST_MAC);
        o_cmd.acc_clr    = (r_tr == 2'd0) && (r_tk == 2'd0);
        o_cmd.tap_row    = r_tr;
        o_cmd.tap_k      = r_tk;
        // left column replicates at the first output column
        if (r_modeb) begin
            o_cmd.win_col = (r_tk == 2'd0) ? 2'd1 : 2'd2;
        end else if (r_tk == 2'd0) begin
            o_cmd.win_col = (r_icol == COL_BITS'(1)) ? 2'd1 : 2'd0;
        end else begin
            o_cmd.win_col = r_tk;
        end
        o_cmd.scale_en   = (r_state == ST_SCALE);
        o_cmd.load_out   = (r_state == ST_EMIT) && i_status.out_free;
        o_cmd.row_end    = r_modeb;
        o_cmd.frame_end  = r_modeb && r_iflush;
    end
endmodule
`default_nettype wire

### hw/rtl/conv3x3_edge_replicate_filter.sv
// Top level of the 3x3 replicate-border convolution filter.
// Depends on cerf_pkg, cerf_cfg, cerf_ctrl, cerf_datapath, cerf_ram.
//
//  channel   signals                                       direction
//  in        i_in_valid / o_in_ready / i_in_data (t_in)    request in
//  out       o_out_valid / i_out_ready / o_out_data (t_out) result out
//  cfg       psel penable pwrite paddr pwdata prdata pready APB, 64-bit, 8-byte stride
//
// First-row requests are only written into a line buffer. Later requests take
// a shift step, plus nine tap steps on the shared MAC, scale and emit for each
// of their results (up to two). Ignored requests are only accepted.
// Reset is synchronous; line buffers are not cleared.
// A waiting result stalls only the emit step; the next request is taken once
// the last result of the current one is in the output register.
`default_nettype none
module conv3x3_edge_replicate_filter (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  cerf_pkg::t_in                        i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output cerf_pkg::t_out                       o_out_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cerf_pkg::PADDR_BITS-1:0] paddr,
    input  wire logic [cerf_pkg::PDATA_BITS-1:0] pwdata,
    output logic      [cerf_pkg::PDATA_BITS-1:0] prdata,
    output logic                                 pready
);
    import cerf_pkg::*;

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    assign pready = 1'b1;

    cerf_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .o_cfg  (cfg)
    );

    cerf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data (i_in_data),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    cerf_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );
endmodule
`default_nettype wire
